### rtl/cgcs_pkg.sv
// shared types, constants and register codes of the serial crc unit
package cgcs_pkg;

   // largest generator degree; larger programmed values saturate here
   localparam int MAX_DEGREE = 32;

   // reset values of the configuration registers
   localparam logic [5:0]  DEGREE_RESET = 6'd16;
   localparam logic [31:0] POLY_RESET   = 32'h0000_1021;

   // queue depths between the parts
   localparam int REQ_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // register index codes, taken from paddr[2]
   localparam logic REG_DEGREE = 1'b0;
   localparam logic REG_POLY   = 1'b1;

   // one input beat
   typedef struct packed {
      logic data_bit;
      logic last;
      logic func;
   } cgcs_item_type;

   // one result beat
   typedef struct packed {
      logic [31:0] remainder;
      logic        error_flag;
   } cgcs_result_type;

   // configuration seen by the division engine
   typedef struct packed {
      logic [5:0]  degree;
      logic [31:0] poly_low_terms;
   } cgcs_cfg_type;

endpackage

### rtl/cgcs_queue.sv
// small first-in first-out queue with full and empty flags
module cgcs_queue
   import cgcs_pkg::*;
#(
   parameter int WIDTH = 3,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/cgcs_csr.sv
// apb configuration registers: generator degree and low polynomial terms
module cgcs_csr
   import cgcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready,
   output cgcs_cfg_type cfg
);

   logic [5:0]  degree_ff, degree_in;
   logic [31:0] poly_ff, poly_in;
   logic        wr_en;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // write decode
   always_comb begin
      degree_in = degree_ff;
      poly_in   = poly_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_DEGREE: degree_in = pwdata[5:0];
            REG_POLY:   poly_in   = pwdata;
            default:    degree_in = degree_ff;
         endcase
      end
   end

   // read decode
   always_comb begin
      unique case (reg_sel)
         REG_DEGREE: prdata = {26'd0, degree_ff};
         REG_POLY:   prdata = poly_ff;
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         poly_ff   <= POLY_RESET;
      end else begin
         degree_ff <= degree_in;
         poly_ff   <= poly_in;
      end
   end

   assign cfg.degree         = degree_ff;
   assign cfg.poly_low_terms = poly_ff;

endmodule

### rtl/cgcs_div.sv
// back end: one long-division step per bit beat, result on the last bit
module cgcs_div
   import cgcs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cgcs_cfg_type    cfg,
   input  logic            item_valid,
   input  cgcs_item_type   item,
   output logic            item_take,
   input  logic            result_full,
   output logic            result_push,
   output cgcs_result_type result
);

   logic [31:0] div_ff, div_in;
   logic [6:0]  eff_deg;
   logic [4:0]  top_idx;
   logic [31:0] mask;
   logic        top;
   logic        feedback;
   logic [31:0] shifted;
   logic [31:0] next_rem;

   // effective degree: zero reads as one, large values saturate
   always_comb begin
      if (cfg.degree == 6'd0) begin
         eff_deg = 7'd1;
      end else if ({1'b0, cfg.degree} > 7'(MAX_DEGREE)) begin
         eff_deg = 7'(MAX_DEGREE);
      end else begin
         eff_deg = {1'b0, cfg.degree};
      end
   end

   // keep bits below the degree
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         mask[i] = (7'(i) < eff_deg);
      end
   end

   // one division step
   assign top_idx  = 5'(eff_deg - 7'd1);
   assign top      = (eff_deg <= 7'd32) ? div_ff[top_idx] : 1'b0;
   assign feedback = item.func ? top : (top ^ item.data_bit);
   assign shifted  = {div_ff[30:0], item.func & item.data_bit} & mask;
   assign next_rem = feedback ? (shifted ^ (cfg.poly_low_terms & mask)) : shifted;

   // take a beat unless it would produce a result with nowhere to go
   assign item_take   = item_valid && (!item.last || !result_full);
   assign result_push = item_take && item.last;

   assign result.remainder  = next_rem;
   assign result.error_flag = item.func && (next_rem != '0);

   // division register, cleared after each last bit
   always_comb begin
      div_in = div_ff;
      if (item_take) begin
         div_in = item.last ? '0 : next_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
      end else begin
         div_ff <= div_in;
      end
   end

   // generate mode never flags an error
   assert property (@(posedge clock) disable iff (reset)
      result_push && !item.func |-> !result.error_flag)
      else $error("error flag set in generate mode");

   // remainder has nothing at or above the degree
   assert property (@(posedge clock) disable iff (reset)
      result_push |-> ((result.remainder & ~mask) == '0))
      else $error("remainder bits above degree");

   // register starts over after a last bit
   assert property (@(posedge clock) disable iff (reset)
      result_push |=> (div_ff == '0))
      else $error("division register not cleared after last bit");

endmodule

### rtl/crc_generate_check_serial_unit.sv
// top level of the bit-serial crc generate and check unit
// Usage:
//   input beats (req_data_bit, req_last, req_func) go in on push while full
//   is low; bits come most significant first, req_last marks the final bit.
//   req_func 0 divides message * x^degree (check value to append), 1 divides
//   the received codeword and raises rsp_error_flag on a nonzero remainder.
//   one result beat per last bit is offered while empty is low and is taken
//   with pop. the apb port sets the degree (byte address 0) and the low
//   polynomial terms (byte address 4); write it only when the unit is idle.
// Timing:
//   one bit per cycle sustained while the result queue has room. a front
//   queue takes beats, the division engine does one shift-and-xor step per
//   taken beat, and a result queue holds finished remainders. a last bit
//   is registered in the front queue, then its result in the result queue.
// Reset: queues empty, remainder zero, degree 16, polynomial 0x1021.
// Stall: with pop low the result queue fills, the engine holds at the next
//   last bit, and full rises once the front queue is full; nothing is lost.
module crc_generate_check_serial_unit
   import cgcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic        req_data_bit,
   input  logic        req_last,
   input  logic        req_func,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_remainder,
   output logic        rsp_error_flag,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cgcs_cfg_type    cfg;
   cgcs_item_type   req_item;
   cgcs_item_type   q_item;
   logic            q_empty;
   logic            item_take;
   logic            result_full;
   logic            result_push;
   cgcs_result_type result;
   cgcs_result_type rsp_item;

   assign req_item.data_bit = req_data_bit;
   assign req_item.last     = req_last;
   assign req_item.func     = req_func;

   // configuration registers
   cgcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // front: input beat queue
   cgcs_queue #(
      .WIDTH ($bits(cgcs_item_type)),
      .DEPTH (REQ_DEPTH)
   ) u_req_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (req_item),
      .full    (full),
      .pop     (item_take),
      .rd_data (q_item),
      .empty   (q_empty)
   );

   // back: division engine
   cgcs_div u_div (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (!q_empty),
      .item        (q_item),
      .item_take   (item_take),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result)
   );

   // result queue
   cgcs_queue #(
      .WIDTH ($bits(cgcs_result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (result_push),
      .wr_data (result),
      .full    (result_full),
      .pop     (pop),
      .rd_data (rsp_item),
      .empty   (empty)
   );

   assign rsp_remainder  = rsp_item.remainder;
   assign rsp_error_flag = rsp_item.error_flag;

   // a flagged error always carries a nonzero remainder
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_error_flag |-> (rsp_remainder != '0))
      else $error("error flag with zero remainder");

   // both queues come out of reset empty
   assert property (@(posedge clock)
      $past(reset) |-> (empty && !full))
      else $error("queues not empty after reset");

   // a beat waiting in the front queue moves on unless results back up
   assert property (@(posedge clock) disable iff (reset)
      !q_empty && !result_full |-> item_take)
      else $error("engine idle with work waiting");

endmodule
